>>> src/fdtb_pkg.sv
package fdtb_pkg;

   // configuration register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_SCREEN_WIDTH       = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT      = 3'd1;
   localparam logic [2:0] REG_DEPTH_TEST_ENABLE  = 3'd2;
   localparam logic [2:0] REG_DEPTH_COMPARE      = 3'd3;
   localparam logic [2:0] REG_DEPTH_WRITE_ENABLE = 3'd4;
   localparam logic [2:0] REG_ALPHA_TEST_ENABLE  = 3'd5;
   localparam logic [2:0] REG_DEPTH_FROM_INTERP  = 3'd6;
   localparam logic [2:0] REG_BLEND_ENABLE       = 3'd7;

   localparam int CSR_ADDR_W = 5;

   // depth compare codes, fragment F against stored S
   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_LE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_GE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;

   // operation codes
   localparam logic OP_FRAGMENT = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [7:0] ALPHA_FULL = 8'd255;

   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      logic rd_en;
      logic wr_depth;
      logic wr_color;
   } store_ctrl_type;

   typedef struct packed {
      logic load;
      logic read_mode;
   } mix_ctrl_type;

endpackage

>>> src/fdtb_store.sv
module fdtb_store #(
   parameter int ADDR_W     = 16,
   parameter int NUM_PIX    = 65536,
   parameter int DEPTH_BITS = 24
) (
   input  logic                     clock,
   input  fdtb_pkg::store_ctrl_type ctrl,
   input  logic [ADDR_W-1:0]        addr,
   input  logic [DEPTH_BITS-1:0]    wr_depth,
   input  logic [31:0]              wr_color,
   output logic [DEPTH_BITS-1:0]    rd_depth,
   output logic [31:0]              rd_color
);

   logic [DEPTH_BITS-1:0] depth_mem [NUM_PIX];
   logic [31:0]           color_mem [NUM_PIX];
   logic [DEPTH_BITS-1:0] rd_depth_ff;
   logic [31:0]           rd_color_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_depth) begin
         depth_mem[addr] <= wr_depth;
      end
      if (ctrl.rd_en) begin
         rd_depth_ff <= depth_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_color) begin
         color_mem[addr] <= wr_color;
      end
      if (ctrl.rd_en) begin
         rd_color_ff <= color_mem[addr];
      end
   end

   assign rd_depth = rd_depth_ff;
   assign rd_color = rd_color_ff;

endmodule

>>> src/fdtb_mix.sv
module fdtb_mix (
   input  logic                   clock,
   input  fdtb_pkg::mix_ctrl_type ctrl,
   input  fdtb_pkg::rgb_type      src_rgb,
   input  logic [7:0]             src_alpha,
   input  logic [31:0]            dst_color,
   output fdtb_pkg::rgb_type      quot
);

   logic [2:0][15:0] num_ff;
   logic [2:0][15:0] num_in;
   logic [7:0]       wgt;
   logic [7:0]       p;
   logic [7:0]       r;
   logic [16:0]      t;
   logic [16:0]      s;

   // read: C*A + 127; blend: S*a + D*(255-a) + 127
   always_comb begin
      wgt = ctrl.read_mode ? dst_color[31:24] : src_alpha;
      for (int ch = 0; ch < 3; ch++) begin
         p = ctrl.read_mode ? dst_color[8*ch +: 8] : src_rgb[ch];
         r = ctrl.read_mode ? 8'd0 : dst_color[8*ch +: 8];
         num_in[ch] = 16'(17'(16'(p) * 16'(wgt)) + 17'(16'(r) * 16'(fdtb_pkg::ALPHA_FULL - wgt))
                      + 17'd127);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         num_ff <= num_in;
      end
   end

   // x / 255 for x below 65535: ((x+1) + ((x+1) >> 8)) >> 8
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         t = 17'(num_ff[ch]) + 17'd1;
         s = t + (t >> 8);
         quot[ch] = s[15:8];
      end
   end

endmodule

>>> src/fragment_depth_test_blend_unit.sv
// Raster output stage: depth test and alpha blend against on-chip depth and RGBA stores of
// MAX_WIDTH*MAX_HEIGHT entries. After reset the unit sweeps both stores, one entry a cycle,
// with req_stall high; CSR writes are taken during the sweep. Items are then handled one at
// a time through a four-step sequencer (accept, store read, test and multiply, write-back);
// write-back waits while the output register is full and stalled. The stores have a single
// read/write port. A finished result sits in an output register while the next item is
// already being worked on.
module fragment_depth_test_blend_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int DEPTH_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [15:0]                  req_pos_x,
   input  logic signed [15:0]                  req_pos_y,
   input  logic [23:0]                         req_interp_depth,
   input  logic [23:0]                         req_shader_depth,
   input  logic [7:0]                          req_src_red,
   input  logic [7:0]                          req_src_green,
   input  logic [7:0]                          req_src_blue,
   input  logic [7:0]                          req_src_alpha,
   input  logic                                req_clip,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_written,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_blue,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdtb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int NUM_PIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(NUM_PIX);
   localparam int DIM_W   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_TEST  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // configuration
   logic [8:0] sw_ff;
   logic [8:0] sh_ff;
   logic       dte_ff;
   logic [2:0] cmp_ff;
   logic       dwe_ff;
   logic       ate_ff;
   logic       dfi_ff;
   logic       ble_ff;
   logic       csr_wr;

   // sequencer
   logic [2:0]        state_ff;
   logic [2:0]        state_in;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] clr_in;
   logic              accept;
   logic              out_free;

   // captured item
   logic                  op_ff;
   logic [15:0]           pos_x_ff;
   logic [15:0]           pos_y_ff;
   logic [23:0]           interp_ff;
   logic [23:0]           shader_ff;
   fdtb_pkg::rgb_type     src_ff;
   logic [7:0]            alpha_ff;
   logic                  clip_ff;

   logic                  on_ff;
   logic                  on_in;
   logic [ADDR_W-1:0]     idx_ff;
   logic [ADDR_W-1:0]     idx_in;
   logic                  pass_ff;
   logic                  pass_in;
   logic [DEPTH_BITS-1:0] frag_depth;
   logic [DEPTH_BITS-1:0] frag_depth_ff;
   logic                  depth_ok;

   logic [DIM_W-1:0]      w_eff;
   logic [DIM_W-1:0]      h_eff;

   // stores and mixer
   fdtb_pkg::store_ctrl_type st_ctrl;
   fdtb_pkg::mix_ctrl_type   mx_ctrl;
   logic [ADDR_W-1:0]        st_addr;
   logic [DEPTH_BITS-1:0]    st_wr_depth;
   logic [31:0]              st_wr_color;
   logic [DEPTH_BITS-1:0]    st_rd_depth;
   logic [31:0]              st_rd_color;
   fdtb_pkg::rgb_type        quot;
   fdtb_pkg::rgb_type        new_rgb;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_written_ff;
   logic [7:0] rsp_red_ff;
   logic [7:0] rsp_green_ff;
   logic [7:0] rsp_blue_ff;
   logic       rsp_load;

   // ---------------------------------------------------------------- CSR
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff  <= 9'd256;
         sh_ff  <= 9'd256;
         dte_ff <= 1'b1;
         cmp_ff <= fdtb_pkg::CMP_LT;
         dwe_ff <= 1'b1;
         ate_ff <= 1'b0;
         dfi_ff <= 1'b1;
         ble_ff <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[4:2])
            fdtb_pkg::REG_SCREEN_WIDTH:       sw_ff  <= pwdata[8:0];
            fdtb_pkg::REG_SCREEN_HEIGHT:      sh_ff  <= pwdata[8:0];
            fdtb_pkg::REG_DEPTH_TEST_ENABLE:  dte_ff <= pwdata[0];
            fdtb_pkg::REG_DEPTH_COMPARE:      cmp_ff <= pwdata[2:0];
            fdtb_pkg::REG_DEPTH_WRITE_ENABLE: dwe_ff <= pwdata[0];
            fdtb_pkg::REG_ALPHA_TEST_ENABLE:  ate_ff <= pwdata[0];
            fdtb_pkg::REG_DEPTH_FROM_INTERP:  dfi_ff <= pwdata[0];
            fdtb_pkg::REG_BLEND_ENABLE:       ble_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         fdtb_pkg::REG_SCREEN_WIDTH:       prdata = 32'(sw_ff);
         fdtb_pkg::REG_SCREEN_HEIGHT:      prdata = 32'(sh_ff);
         fdtb_pkg::REG_DEPTH_TEST_ENABLE:  prdata = 32'(dte_ff);
         fdtb_pkg::REG_DEPTH_COMPARE:      prdata = 32'(cmp_ff);
         fdtb_pkg::REG_DEPTH_WRITE_ENABLE: prdata = 32'(dwe_ff);
         fdtb_pkg::REG_ALPHA_TEST_ENABLE:  prdata = 32'(ate_ff);
         fdtb_pkg::REG_DEPTH_FROM_INTERP:  prdata = 32'(dfi_ff);
         fdtb_pkg::REG_BLEND_ENABLE:       prdata = 32'(ble_ff);
         default:                          prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- item capture
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         interp_ff <= req_interp_depth;
         shader_ff <= req_shader_depth;
         src_ff    <= {req_src_blue, req_src_green, req_src_red};
         alpha_ff  <= req_src_alpha;
         clip_ff   <= req_clip;
      end
   end

   // ---------------------------------------------------------------- address and screen check
   // register values above the store size act as the store size
   always_comb begin
      w_eff = (32'(sw_ff) > 32'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : DIM_W'(sw_ff);
      h_eff = (32'(sh_ff) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(sh_ff);
      on_in = !pos_x_ff[15] && !pos_y_ff[15]
              && (pos_x_ff < 16'(w_eff)) && (pos_y_ff < 16'(h_eff));
      idx_in = ADDR_W'(32'(pos_y_ff[14:0]) * 32'(MAX_WIDTH) + 32'(pos_x_ff[14:0]));
   end

   // ---------------------------------------------------------------- depth test
   always_comb begin
      frag_depth = dfi_ff ? DEPTH_BITS'(interp_ff) : DEPTH_BITS'(shader_ff);
      depth_ok   = 1'b1;
      if (dte_ff) begin
         case (cmp_ff)
            fdtb_pkg::CMP_EQ: depth_ok = (frag_depth == st_rd_depth);
            fdtb_pkg::CMP_LE: depth_ok = (frag_depth <= st_rd_depth);
            fdtb_pkg::CMP_LT: depth_ok = (frag_depth <  st_rd_depth);
            fdtb_pkg::CMP_GE: depth_ok = (frag_depth >= st_rd_depth);
            fdtb_pkg::CMP_GT: depth_ok = (frag_depth >  st_rd_depth);
            default:          depth_ok = 1'b1;
         endcase
      end
      pass_in = on_ff && (op_ff == fdtb_pkg::OP_FRAGMENT) && !(clip_ff && ate_ff) && depth_ok;
   end

   // ---------------------------------------------------------------- sequencer
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_PIX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_TEST;
         ST_TEST: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         on_ff  <= on_in;
         idx_ff <= idx_in;
      end
      if (state_ff == ST_TEST) begin
         pass_ff       <= pass_in;
         frag_depth_ff <= frag_depth;
      end
   end

   // ---------------------------------------------------------------- store access
   assign new_rgb = ble_ff ? quot : src_ff;

   always_comb begin
      st_ctrl     = '0;
      st_addr     = idx_in;
      st_wr_depth = frag_depth_ff;
      st_wr_color = {fdtb_pkg::ALPHA_FULL, new_rgb};
      case (state_ff)
         ST_CLEAR: begin
            st_ctrl.wr_depth = 1'b1;
            st_ctrl.wr_color = 1'b1;
            st_addr          = clr_ff;
            st_wr_depth      = '1;
            st_wr_color      = '0;
         end
         ST_ADDR: begin
            st_ctrl.rd_en = on_in;
         end
         ST_DONE: begin
            st_addr          = idx_ff;
            st_ctrl.wr_color = rsp_load && pass_ff;
            st_ctrl.wr_depth = rsp_load && pass_ff && dwe_ff;
         end
         default: ;
      endcase
   end

   fdtb_store #(
      .ADDR_W     (ADDR_W),
      .NUM_PIX    (NUM_PIX),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_store (
      .clock    (clock),
      .ctrl     (st_ctrl),
      .addr     (st_addr),
      .wr_depth (st_wr_depth),
      .wr_color (st_wr_color),
      .rd_depth (st_rd_depth),
      .rd_color (st_rd_color)
   );

   assign mx_ctrl.load      = (state_ff == ST_TEST);
   assign mx_ctrl.read_mode = (op_ff == fdtb_pkg::OP_READ);

   fdtb_mix u_mix (
      .clock     (clock),
      .ctrl      (mx_ctrl),
      .src_rgb   (src_ff),
      .src_alpha (alpha_ff),
      .dst_color (st_rd_color),
      .quot      (quot)
   );

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_written_ff <= pass_ff;
         if (on_ff && op_ff == fdtb_pkg::OP_READ) begin
            rsp_red_ff   <= quot[0];
            rsp_green_ff <= quot[1];
            rsp_blue_ff  <= quot[2];
         end else begin
            rsp_red_ff   <= 8'd0;
            rsp_green_ff <= 8'd0;
            rsp_blue_ff  <= 8'd0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_written   = rsp_written_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;

   // ---------------------------------------------------------------- assertions
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside write-back");

   a_store_write_ok: assert property (@(posedge clock) disable iff (reset)
      st_ctrl.wr_color |-> (state_ff == ST_CLEAR) || (state_ff == ST_DONE && pass_ff && on_ff))
      else $error("colour store written without a passing fragment");

   a_written_no_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_written_ff |->
         rsp_red_ff == 8'd0 && rsp_green_ff == 8'd0 && rsp_blue_ff == 8'd0)
      else $error("written fragment returned colour");

endmodule

>>> tb/fragment_depth_test_blend_unit_tb.sv
`timescale 1ns / 1ps

module fragment_depth_test_blend_unit_tb;

   localparam int SCREEN_MAX    = 256;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 100;

   typedef struct {
      logic               op;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [23:0]        interp_depth;
      logic [23:0]        shader_depth;
      logic [7:0]         src_red;
      logic [7:0]         src_green;
      logic [7:0]         src_blue;
      logic [7:0]         src_alpha;
      logic               clip;
   } pixel_op_type;

   typedef struct {
      logic       written;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } pixel_result_type;

   typedef struct {
      logic [8:0] width;
      logic [8:0] height;
      logic       test_en;
      logic [2:0] compare;
      logic       write_en;
      logic       alpha_test;
      logic       from_interp;
      logic       blend;
   } rop_config_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, req_op, req_clip;
   logic signed [15:0] req_pos_x, req_pos_y;
   logic [23:0] req_interp_depth, req_shader_depth;
   logic [7:0] req_src_red, req_src_green, req_src_blue, req_src_alpha;
   logic rsp_valid, rsp_stall, rsp_written;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic psel, penable, pwrite, pready;
   logic [fdtb_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   // shadow copies of the stores and registers
   logic [23:0] depth_shadow [SCREEN_MAX*SCREEN_MAX] = '{default: '1};
   logic [31:0] color_shadow [SCREEN_MAX*SCREEN_MAX] = '{default: '0};
   rop_config_type rop_cfg = '{width: 9'd256, height: 9'd256, test_en: 1'b1,
                               compare: fdtb_pkg::CMP_LT, write_en: 1'b1, alpha_test: 1'b0,
                               from_interp: 1'b1, blend: 1'b0};

   pixel_result_type pixel_results_due [$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  sender_idles = 1'b0;
   bit  receiver_idles = 1'b0;
   bit  hold_output = 1'b0;

   fragment_depth_test_blend_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_interp_depth (req_interp_depth),
      .req_shader_depth (req_shader_depth),
      .req_src_red      (req_src_red),
      .req_src_green    (req_src_green),
      .req_src_blue     (req_src_blue),
      .req_src_alpha    (req_src_alpha),
      .req_clip         (req_clip),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_written      (rsp_written),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pixel_results_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [7:0] premultiply(input logic [7:0] chan, input logic [7:0] alpha);
      int unsigned c, a;
      c = 32'(chan);
      a = 32'(alpha);
      return 8'((c * a + 127) / 255);
   endfunction

   function automatic logic [7:0] blend_channel(input logic [7:0] src, input logic [7:0] dst,
                                                input logic [7:0] alpha);
      int unsigned s, d, a;
      s = 32'(src);
      d = 32'(dst);
      a = 32'(alpha);
      return 8'((s * a + d * (255 - a) + 127) / 255);
   endfunction

   // expected output of one op; updates the shadow stores as the unit would
   function automatic pixel_result_type raster_op_result(input pixel_op_type item);
      pixel_result_type res;
      int w, h, idx;
      logic [23:0] frag_depth, held_depth;
      logic [31:0] stored;
      logic pass;
      res = '{written: 1'b0, out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0};
      w = (rop_cfg.width > SCREEN_MAX) ? SCREEN_MAX : int'(rop_cfg.width);
      h = (rop_cfg.height > SCREEN_MAX) ? SCREEN_MAX : int'(rop_cfg.height);
      if (item.pos_x < 0 || item.pos_y < 0 || item.pos_x >= w || item.pos_y >= h)
         return res;
      idx = int'(item.pos_y) * SCREEN_MAX + int'(item.pos_x);
      stored = color_shadow[idx];
      if (item.op == fdtb_pkg::OP_READ) begin
         res.out_red   = premultiply(stored[7:0], stored[31:24]);
         res.out_green = premultiply(stored[15:8], stored[31:24]);
         res.out_blue  = premultiply(stored[23:16], stored[31:24]);
         return res;
      end
      if (item.clip && rop_cfg.alpha_test)
         return res;
      frag_depth = rop_cfg.from_interp ? item.interp_depth : item.shader_depth;
      held_depth = depth_shadow[idx];
      if (!rop_cfg.test_en) begin
         pass = 1'b1;
      end else begin
         case (rop_cfg.compare)
            fdtb_pkg::CMP_EQ: pass = (frag_depth == held_depth);
            fdtb_pkg::CMP_LE: pass = (frag_depth <= held_depth);
            fdtb_pkg::CMP_LT: pass = (frag_depth < held_depth);
            fdtb_pkg::CMP_GE: pass = (frag_depth >= held_depth);
            fdtb_pkg::CMP_GT: pass = (frag_depth > held_depth);
            default:          pass = 1'b1;
         endcase
      end
      if (!pass)
         return res;
      if (rop_cfg.write_en)
         depth_shadow[idx] = frag_depth;
      if (rop_cfg.blend) begin
         color_shadow[idx] = {fdtb_pkg::ALPHA_FULL,
                              blend_channel(item.src_blue, stored[23:16], item.src_alpha),
                              blend_channel(item.src_green, stored[15:8], item.src_alpha),
                              blend_channel(item.src_red, stored[7:0], item.src_alpha)};
      end else begin
         color_shadow[idx] = {fdtb_pkg::ALPHA_FULL, item.src_blue, item.src_green,
                              item.src_red};
      end
      res.written = 1'b1;
      return res;
   endfunction

   // result transfers
   always @(posedge clock) begin
      pixel_result_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pixel_results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual written %0d rgb %0d %0d %0d",
                     $time, rsp_written, rsp_out_red, rsp_out_green, rsp_out_blue);
            mismatch_count++;
         end else begin
            want = pixel_results_due.pop_front();
            if (rsp_written !== want.written) begin
               $display("%0t: written mismatch, expected %0d actual %0d",
                        $time, want.written, rsp_written);
               mismatch_count++;
            end
            if (rsp_out_red !== want.out_red) begin
               $display("%0t: out_red mismatch, expected %0d actual %0d",
                        $time, want.out_red, rsp_out_red);
               mismatch_count++;
            end
            if (rsp_out_green !== want.out_green) begin
               $display("%0t: out_green mismatch, expected %0d actual %0d",
                        $time, want.out_green, rsp_out_green);
               mismatch_count++;
            end
            if (rsp_out_blue !== want.out_blue) begin
               $display("%0t: out_blue mismatch, expected %0d actual %0d",
                        $time, want.out_blue, rsp_out_blue);
               mismatch_count++;
            end
         end
      end
   end

   // result sink: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int unsigned pause;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            pause = HOLD_CYCLES;
         end else begin
            pause = receiver_idles ? $urandom_range(0, 16) : 0;
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic program_registers(input rop_config_type cfg);
      logic [31:0] value;
      int i;
      for (i = int'(fdtb_pkg::REG_SCREEN_WIDTH); i <= int'(fdtb_pkg::REG_BLEND_ENABLE); i++) begin
         case (3'(i))
            fdtb_pkg::REG_SCREEN_WIDTH:       value = 32'(cfg.width);
            fdtb_pkg::REG_SCREEN_HEIGHT:      value = 32'(cfg.height);
            fdtb_pkg::REG_DEPTH_TEST_ENABLE:  value = 32'(cfg.test_en);
            fdtb_pkg::REG_DEPTH_COMPARE:      value = 32'(cfg.compare);
            fdtb_pkg::REG_DEPTH_WRITE_ENABLE: value = 32'(cfg.write_en);
            fdtb_pkg::REG_ALPHA_TEST_ENABLE:  value = 32'(cfg.alpha_test);
            fdtb_pkg::REG_DEPTH_FROM_INTERP:  value = 32'(cfg.from_interp);
            default:                          value = 32'(cfg.blend);
         endcase
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {3'(i), 2'b00};
         pwdata  <= value;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (pready !== 1'b1);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      rop_cfg = cfg;
   endtask

   task automatic send_pixel_op(input pixel_op_type item);
      int unsigned gap;
      pixel_result_type expected;
      gap = sender_idles ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= item.op;
      req_pos_x        <= item.pos_x;
      req_pos_y        <= item.pos_y;
      req_interp_depth <= item.interp_depth;
      req_shader_depth <= item.shader_depth;
      req_src_red      <= item.src_red;
      req_src_green    <= item.src_green;
      req_src_blue     <= item.src_blue;
      req_src_alpha    <= item.src_alpha;
      req_clip         <= item.clip;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected = raster_op_result(item);
      pixel_results_due = {pixel_results_due, expected};
   endtask

   // register writes only happen once this returns
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pixel_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_op_type make_op(input logic op, input int x, input int y,
                                            input logic [23:0] idepth,
                                            input logic [23:0] sdepth,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a,
                                            input logic clip);
      pixel_op_type item;
      item.op           = op;
      item.pos_x        = 16'(x);
      item.pos_y        = 16'(y);
      item.interp_depth = idepth;
      item.shader_depth = sdepth;
      item.src_red      = r;
      item.src_green    = g;
      item.src_blue     = b;
      item.src_alpha    = a;
      item.clip         = clip;
      return item;
   endfunction

   // mostly a small patch so pixels are revisited; sometimes edges and far off screen
   function automatic logic signed [15:0] random_coord(input logic [8:0] size);
      int lim;
      lim = (size > SCREEN_MAX) ? SCREEN_MAX : int'(size);
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'(lim);
         2:       return 16'(lim - 1);
         3:       return $urandom_range(0, 1) ? -16'sd1 : 16'sh8000;
         default: return 16'($urandom_range(0, 11));
      endcase
   endfunction

   // few distinct depths so that equal compares come up
   function automatic logic [23:0] random_depth();
      case ($urandom_range(0, 3))
         0:       return 24'($urandom);
         1:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         default: return 24'($urandom_range(0, 7)) << 21;
      endcase
   endfunction

   function automatic pixel_op_type random_pixel_op();
      pixel_op_type item;
      item.op           = ($urandom_range(0, 3) == 0) ? fdtb_pkg::OP_READ : fdtb_pkg::OP_FRAGMENT;
      item.pos_x        = random_coord(rop_cfg.width);
      item.pos_y        = random_coord(rop_cfg.height);
      item.interp_depth = random_depth();
      item.shader_depth = random_depth();
      item.src_red      = 8'($urandom);
      item.src_green    = 8'($urandom);
      item.src_blue     = 8'($urandom);
      case ($urandom_range(0, 5))
         0:       item.src_alpha = 8'd0;
         1:       item.src_alpha = 8'd255;
         default: item.src_alpha = 8'($urandom);
      endcase
      item.clip = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic logic [8:0] random_size();
      case ($urandom_range(0, 5))
         0:       return 9'd1;
         1:       return 9'd256;
         2:       return 9'd511;
         3:       return 9'd257;
         default: return 9'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic rop_config_type random_config();
      rop_config_type cfg;
      cfg.width       = random_size();
      cfg.height      = random_size();
      cfg.test_en     = ($urandom_range(0, 4) != 0);
      cfg.compare     = 3'($urandom_range(0, 7));
      cfg.write_en    = 1'($urandom_range(0, 1));
      cfg.alpha_test  = 1'($urandom_range(0, 1));
      cfg.from_interp = 1'($urandom_range(0, 1));
      cfg.blend       = 1'($urandom_range(0, 1));
      return cfg;
   endfunction

   // reset register values, fresh stores
   task automatic test_store_defaults();
      send_pixel_op(make_op(fdtb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 0, 0, 24'h100000, 24'hABCDEF,
                            10, 20, 30, 128, 1'b1));
      send_pixel_op(make_op(fdtb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 0, 0, 24'h100000, 0,
                            1, 2, 3, 4, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 255, 255, 24'hFFFFFF, 0,
                            9, 9, 9, 9, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 255, 255, 24'h000000, 0,
                            255, 255, 255, 255, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 256, 0, 0, 0, 5, 5, 5, 5, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 0, 256, 0, 0, 5, 5, 5, 5, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, -1, 0, 0, 0, 5, 5, 5, 5, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, -32768, 32767, 0, 0,
                            5, 5, 5, 5, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_READ, -1, -1, 0, 0, 0, 0, 0, 0, 1'b0));
      drain_results();
   endtask

   // alpha test, shader depth, blending, depth write off
   task automatic test_fragment_controls();
      program_registers('{width: 9'd256, height: 9'd256, test_en: 1'b1,
                          compare: fdtb_pkg::CMP_GE, write_en: 1'b0, alpha_test: 1'b1,
                          from_interp: 1'b0, blend: 1'b1});
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 1, 1, 0, 24'hFFFFFF,
                            50, 60, 70, 255, 1'b1));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 1, 1, 24'hFFFFFF, 24'hFFFFFF,
                            200, 100, 50, 0, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 1, 1, 24'hFFFFFF, 24'h123456,
                            7, 7, 7, 255, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 1, 1, 0, 24'hFFFFFF,
                            200, 100, 50, 255, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 1, 1, 0, 24'hFFFFFF,
                            0, 0, 255, 128, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_READ, 1, 1, 0, 0, 0, 0, 0, 0, 1'b0));
      drain_results();
   endtask

   task automatic test_compare_codes();
      rop_config_type cfg;
      logic [2:0] code;
      cfg = '{width: 9'd256, height: 9'd256, test_en: 1'b1, compare: fdtb_pkg::CMP_EQ,
              write_en: 1'b1, alpha_test: 1'b0, from_interp: 1'b1, blend: 1'b0};
      code = fdtb_pkg::CMP_EQ;
      repeat (8) begin
         cfg.compare = code;
         program_registers(cfg);
         send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 2, 2,
                               (code == fdtb_pkg::CMP_EQ) ? 24'hFFFFFF : 24'h800000, 0,
                               8'(code), 8'(code), 8'(code), 8'd255, 1'b0));
         drain_results();
         code++;
      end
   endtask

   // zero size and sizes beyond the store
   task automatic test_screen_limits();
      rop_config_type cfg;
      cfg = '{width: 9'd0, height: 9'd256, test_en: 1'b0, compare: fdtb_pkg::CMP_LT,
              write_en: 1'b1, alpha_test: 1'b0, from_interp: 1'b1, blend: 1'b0};
      program_registers(cfg);
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 0, 0, 0, 0, 1, 1, 1, 1, 1'b0));
      drain_results();
      cfg.width  = 9'd511;
      cfg.height = 9'd511;
      program_registers(cfg);
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 255, 255, 24'h000123, 0,
                            11, 22, 33, 44, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_FRAGMENT, 256, 256, 0, 0, 1, 1, 1, 1, 1'b0));
      send_pixel_op(make_op(fdtb_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 1'b0));
      drain_results();
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_registers(random_config());
         sender_idles   = phase[0];
         receiver_idles = phase[1];
         repeat (PHASE_ITEMS) send_pixel_op(random_pixel_op());
         drain_results();
      end
   endtask

   // sink holds off while the source keeps offering, so the unit backs up
   task automatic test_backpressure();
      program_registers(random_config());
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      hold_output    = 1'b1;
      repeat (PHASE_ITEMS) send_pixel_op(random_pixel_op());
      drain_results();
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= fdtb_pkg::OP_FRAGMENT;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_interp_depth <= '0;
      req_shader_depth <= '0;
      req_src_red      <= '0;
      req_src_green    <= '0;
      req_src_blue     <= '0;
      req_src_alpha    <= '0;
      req_clip         <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_store_defaults();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      test_fragment_controls();
      test_compare_codes();
      test_screen_limits();
      test_random_traffic();
      test_backpressure();

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
